// File: sv/bfa_pkg.sv
// shared constants and types for the best-fit block allocator
package bfa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam int AMT_W = 16;
  localparam int BLK_W = 5;
  localparam int REM_W = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_REQ  = 1'b1;

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_NOFIT  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // search beat handed from cell to cell
  typedef struct packed {
    logic                 vld;
    logic [SIZE_BITS-1:0] req;
    logic                 found;
    logic [SIZE_BITS-1:0] best_size;
    logic [IDX_W-1:0]     best_idx;
  } token_t;

  // write broadcast to all cells
  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] data;
  } wr_t;

endpackage

// File: sv/best_fit_block_allocator.sv
// Best-fit block allocator. A row of cells holds one block's free size each; a load beat
// (tuser 0) appends a block and returns its number, or reports a full row; a request beat
// (tuser 1) sends a search beat down the row, one cell per cycle, that keeps the smallest
// free size at least the request (lowest block on a tie), then writes the reduced size
// back if a block fits. One item is in work at a time: a load passes S_LOAD; a request
// passes S_SCAN, which waits for the search beat to leave the last cell, then S_DONE.
// S_LOAD and S_DONE write the result register once it is free, and the next beat is taken
// back in S_IDLE. The result register lets the next item be accepted while a result still
// waits to be taken; that item's result then waits until the old one is taken.
module best_fit_block_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [15:0] amount
  input  logic        s_axis_tuser_i,  // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // [4:0] block_number, [20:5] remaining, [23:21] zero
  output logic [1:0]  m_axis_tuser_o   // [1:0] status
);

  bfa_pkg::token_t                  chain [bfa_pkg::MAX_BLOCKS+1];
  bfa_pkg::wr_t                     wr;
  logic [bfa_pkg::CNT_W-1:0]        count;
  bfa_pkg::status_e                 status;
  logic [bfa_pkg::BLK_W-1:0]        blk;
  logic [bfa_pkg::REM_W-1:0]        rem;

  bfa_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_amount_i      (s_axis_tdata_i),
    .s_cmd_i         (s_axis_tuser_i),
    .tok_o           (chain[0]),
    .tok_i           (chain[bfa_pkg::MAX_BLOCKS]),
    .wr_o            (wr),
    .count_o         (count),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_status_o      (status),
    .m_block_o       (blk),
    .m_remaining_o   (rem)
  );

  for (genvar i = 0; i < bfa_pkg::MAX_BLOCKS; i++) begin : g_cell
    bfa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (bfa_pkg::IDX_W'(i)),
      .count_i    (count),
      .wr_i       (wr),
      .tok_i      (chain[i]),
      .tok_o      (chain[i+1])
    );
  end

  assign m_axis_tdata_o = {3'b000, rem, blk};
  assign m_axis_tuser_o = status;

endmodule

// File: sv/bfa_cell.sv
// one table entry: holds a free size and updates the passing search beat
module bfa_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bfa_pkg::IDX_W-1:0]  cell_idx_i,
  input  logic [bfa_pkg::CNT_W-1:0]  count_i,
  input  bfa_pkg::wr_t               wr_i,
  input  bfa_pkg::token_t            tok_i,
  output bfa_pkg::token_t            tok_o
);

  logic [bfa_pkg::SIZE_BITS-1:0] size_q;
  bfa_pkg::token_t               tok_d, tok_q;
  logic                          active, take;

  always_comb begin
    active = bfa_pkg::CNT_W'(cell_idx_i) < count_i;
    // strict compare keeps the lowest block on ties
    take   = active && (size_q >= tok_i.req) &&
             (!tok_i.found || (size_q < tok_i.best_size));
    tok_d  = tok_i;
    if (take) begin
      tok_d.found     = 1'b1;
      tok_d.best_size = size_q;
      tok_d.best_idx  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we && (wr_i.idx == cell_idx_i)) begin
      size_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: sv/bfa_ctrl.sv
// sequencer: block count, search launch, write-back and result register
module bfa_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [bfa_pkg::AMT_W-1:0]  s_amount_i,
  input  logic                       s_cmd_i,
  output bfa_pkg::token_t            tok_o,
  input  bfa_pkg::token_t            tok_i,
  output bfa_pkg::wr_t               wr_o,
  output logic [bfa_pkg::CNT_W-1:0]  count_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output bfa_pkg::status_e           m_status_o,
  output logic [bfa_pkg::BLK_W-1:0]  m_block_o,
  output logic [bfa_pkg::REM_W-1:0]  m_remaining_o
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_SCAN, S_DONE} state_e;

  state_e                         state_q, state_d;
  logic [bfa_pkg::SIZE_BITS-1:0]  amt_q, amt_d;
  logic [bfa_pkg::CNT_W-1:0]      count_q, count_d;
  bfa_pkg::token_t                tok_q, tok_d;
  bfa_pkg::wr_t                   wr_q, wr_d;
  logic                           found_q, found_d;
  logic [bfa_pkg::IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [bfa_pkg::SIZE_BITS-1:0]  best_size_q, best_size_d;
  logic                           out_vld_q, out_vld_d;
  bfa_pkg::status_e               out_st_q, out_st_d;
  logic [bfa_pkg::BLK_W-1:0]      out_blk_q, out_blk_d;
  logic [bfa_pkg::REM_W-1:0]      out_rem_q, out_rem_d;

  logic                           slot_free;
  logic                           in_beat;
  logic [bfa_pkg::SIZE_BITS-1:0]  amt_in;
  logic [bfa_pkg::SIZE_BITS-1:0]  left;
  logic [bfa_pkg::CNT_W-1:0]      blk_alloc;

  assign slot_free = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign amt_in    = bfa_pkg::SIZE_BITS'(s_amount_i);
  assign left      = best_size_q - amt_q;
  assign blk_alloc = bfa_pkg::CNT_W'(best_idx_q) + bfa_pkg::CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    amt_d       = amt_q;
    count_d     = count_q;
    tok_d       = tok_q;
    wr_d        = wr_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    out_vld_d   = out_vld_q;
    out_st_d    = out_st_q;
    out_blk_d   = out_blk_q;
    out_rem_d   = out_rem_q;
    tok_d.vld   = 1'b0;
    wr_d.we     = 1'b0;
    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          amt_d = amt_in;
          if (s_cmd_i == bfa_pkg::CMD_LOAD) begin
            state_d = S_LOAD;
          end else begin
            tok_d.vld       = 1'b1;
            tok_d.req       = amt_in;
            tok_d.found     = 1'b0;
            tok_d.best_size = '0;
            tok_d.best_idx  = '0;
            state_d         = S_SCAN;
          end
        end
      end
      S_LOAD: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          out_rem_d = '0;
          if (count_q == bfa_pkg::CNT_W'(bfa_pkg::MAX_BLOCKS)) begin
            out_st_d  = bfa_pkg::ST_FULL;
            out_blk_d = '0;
          end else begin
            wr_d.we   = 1'b1;
            wr_d.idx  = bfa_pkg::IDX_W'(count_q);
            wr_d.data = amt_q;
            count_d   = count_q + bfa_pkg::CNT_W'(1);
            out_st_d  = bfa_pkg::ST_LOADED;
            out_blk_d = bfa_pkg::BLK_W'(count_q + bfa_pkg::CNT_W'(1));
          end
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        // wait for the search beat to leave the last cell
        if (tok_i.vld) begin
          found_d     = tok_i.found;
          best_idx_d  = tok_i.best_idx;
          best_size_d = tok_i.best_size;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          if (found_q) begin
            wr_d.we   = 1'b1;
            wr_d.idx  = best_idx_q;
            wr_d.data = left;
            out_st_d  = bfa_pkg::ST_ALLOC;
            out_blk_d = bfa_pkg::BLK_W'(blk_alloc);
            out_rem_d = bfa_pkg::REM_W'(left);
          end else begin
            out_st_d  = bfa_pkg::ST_NOFIT;
            out_blk_d = '0;
            out_rem_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      tok_q       <= '0;
      wr_q        <= '0;
      out_vld_q   <= 1'b0;
      out_st_q    <= bfa_pkg::ST_LOADED;
      out_blk_q   <= '0;
      out_rem_q   <= '0;
      amt_q       <= '0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_size_q <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      tok_q       <= tok_d;
      wr_q        <= wr_d;
      out_vld_q   <= out_vld_d;
      out_st_q    <= out_st_d;
      out_blk_q   <= out_blk_d;
      out_rem_q   <= out_rem_d;
      amt_q       <= amt_d;
      found_q     <= found_d;
      best_idx_q  <= best_idx_d;
      best_size_q <= best_size_d;
    end
  end

  assign tok_o           = tok_q;
  assign wr_o            = wr_q;
  assign count_o         = count_q;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_status_o      = out_st_q;
  assign m_block_o       = out_blk_q;
  assign m_remaining_o   = out_rem_q;

endmodule

// File: sv/bfa_checker.sv
// port-level checks for the best-fit block allocator, bound to the top level
module bfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // a result that waits must stay
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  // a load reports a nonzero block and nothing left
  a_load_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == bfa_pkg::ST_LOADED) |->
      (m_axis_tdata_o[4:0] != 5'd0) && (m_axis_tdata_o[20:5] == 16'd0))
    else $error("bad load result");

  // failures carry no block and no size
  a_fail_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && ((m_axis_tuser_o == bfa_pkg::ST_NOFIT) ||
      (m_axis_tuser_o == bfa_pkg::ST_FULL)) |-> (m_axis_tdata_o == 24'd0))
    else $error("bad failure result");

endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
